/* rtl/prim_mst_pkg.sv */
// Shared types and codes for the Prim spanning tree engine.
// No dependencies; imported by prim_mst_cell and prim_minimum_spanning_tree.
package prim_mst_pkg;

    // Request command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Control broadcast from the sequencer to every vertex cell
    typedef struct packed {
        logic clear;   // start of a run: wipe key, parent and tree marks
        logic mark;    // move the vertex named by mark_idx into the tree
        logic relax;   // one matrix entry of the current row is on the bus
    } prim_mst_ctl_t;

endpackage

/* rtl/prim_mst_in_if.sv */
// Request channel: matrix loads and run commands.
// Depends on nothing.
interface prim_mst_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] weight;

    modport source (output valid, command, row, col, weight, input ready);
    modport sink   (input valid, command, row, col, weight, output ready);
endinterface

/* rtl/prim_mst_out_if.sv */
// Result channel: one tree entry per vertex after a run.
// Depends on nothing.
interface prim_mst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  vertex;
    logic [3:0]  parent;
    logic [15:0] edge_weight;
    logic        is_root;
    logic        reached;
    logic        last;

    modport source (output valid, vertex, parent, edge_weight, is_root, reached, last,
                    input ready);
    modport sink   (input valid, vertex, parent, edge_weight, is_root, reached, last,
                    output ready);
endinterface

/* rtl/prim_mst_cfg_if.sv */
// Configuration write channel carrying the root vertex.
// Depends on nothing.
interface prim_mst_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/prim_mst_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module prim_mst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/prim_mst_cell.sv */
// One vertex cell: key, parent and tree mark, plus one stage of the
// minimum-search token chain. Depends on prim_mst_pkg.
module prim_mst_cell #(
    parameter int WEIGHT_BITS = 16,
    parameter int VERTEX_BITS = 4,
    parameter int CELL_INDEX  = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  prim_mst_pkg::prim_mst_ctl_t   ctl,
    input  logic [VERTEX_BITS-1:0]        mark_idx,
    input  logic [VERTEX_BITS-1:0]        rel_src,
    input  logic [VERTEX_BITS-1:0]        rel_col,
    input  logic [WEIGHT_BITS-1:0]        rel_weight,
    input  logic                          tok_vld_in,
    input  logic                          tok_found_in,
    input  logic [VERTEX_BITS-1:0]        tok_idx_in,
    input  logic [WEIGHT_BITS-1:0]        tok_key_in,
    output logic                          tok_vld_out,
    output logic                          tok_found_out,
    output logic [VERTEX_BITS-1:0]        tok_idx_out,
    output logic [WEIGHT_BITS-1:0]        tok_key_out,
    output logic [WEIGHT_BITS-1:0]        key,
    output logic                          in_tree,
    output logic [VERTEX_BITS-1:0]        parent
);
    import prim_mst_pkg::*;

    localparam logic [VERTEX_BITS-1:0] MY_IDX = VERTEX_BITS'(CELL_INDEX);

    logic [WEIGHT_BITS-1:0] key_reg, key_next;
    logic                   kvld_reg, kvld_next;
    logic                   tree_reg, tree_next;
    logic [VERTEX_BITS-1:0] parent_reg, parent_next;
    logic                   tok_vld_reg, tok_vld_next;
    logic                   tok_found_reg, tok_found_next;
    logic [VERTEX_BITS-1:0] tok_idx_reg, tok_idx_next;
    logic [WEIGHT_BITS-1:0] tok_key_reg, tok_key_next;
    logic                   mark_hit, rel_hit, cand, take;
    prim_mst_ctl_t          ctl_q;

    assign ctl_q = ctl;

    always_comb
    begin
        mark_hit = ctl_q.mark && (mark_idx == MY_IDX);
        rel_hit  = ctl_q.relax && (rel_col == MY_IDX) && (rel_weight != '0) && !tree_reg
                   && (!kvld_reg || (rel_weight < key_reg));
        cand     = kvld_reg && !tree_reg;
        // strict compare keeps the lower index on equal keys
        take     = cand && (!tok_found_in || (key_reg < tok_key_in));

        key_next    = key_reg;
        kvld_next   = kvld_reg;
        tree_next   = tree_reg;
        parent_next = parent_reg;
        if (ctl_q.clear)
        begin
            tree_next   = mark_hit;
            kvld_next   = 1'b0;
            key_next    = '0;
            parent_next = '0;
        end
        else
        begin
            if (mark_hit)
            begin
                tree_next = 1'b1;
            end
            if (rel_hit)
            begin
                key_next    = rel_weight;
                kvld_next   = 1'b1;
                parent_next = rel_src;
            end
        end

        tok_vld_next   = tok_vld_in;
        tok_found_next = tok_found_in || cand;
        tok_idx_next   = take ? MY_IDX : tok_idx_in;
        tok_key_next   = take ? key_reg : tok_key_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kvld_reg    <= 1'b0;
            tree_reg    <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else
        begin
            kvld_reg    <= kvld_next;
            tree_reg    <= tree_next;
            tok_vld_reg <= tok_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        parent_reg    <= parent_next;
        tok_found_reg <= tok_found_next;
        tok_idx_reg   <= tok_idx_next;
        tok_key_reg   <= tok_key_next;
    end

    assign tok_vld_out   = tok_vld_reg;
    assign tok_found_out = tok_found_reg;
    assign tok_idx_out   = tok_idx_reg;
    assign tok_key_out   = tok_key_reg;
    assign key           = key_reg;
    assign in_tree       = tree_reg;
    assign parent        = parent_reg;
endmodule

/* rtl/prim_minimum_spanning_tree.sv */
// Top level of the Prim spanning tree engine: sequencer, matrix RAM and cell row.
// Depends on prim_mst_pkg, the three channel interfaces, prim_mst_ram, prim_mst_cell.
//
// A load request writes one weight; loads with row or col not below
// NUM_VERTICES are dropped. In a run (V = NUM_VERTICES), each vertex moved
// into the tree has its matrix row streamed out of the single RAM read port
// into the cells, and then the minimum-search token walks the cell row to
// pick the next vertex; the run then emits V results, one per cycle when the
// result side is ready. A run stops early when no vertex outside the tree
// has a key; the rest report reached=0.
// Requests are taken only while no run is in progress.
module prim_minimum_spanning_tree #(
    parameter int NUM_VERTICES = 16,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    prim_mst_cfg_if.sink   setup,
    prim_mst_in_if.sink    request,
    prim_mst_out_if.source result
);
    import prim_mst_pkg::*;

    localparam int VB = $clog2(NUM_VERTICES);
    localparam int AW = $clog2(NUM_VERTICES * NUM_VERTICES);
    localparam int CB = $clog2(NUM_VERTICES + 1);
    localparam logic [VB-1:0] LAST_V = VB'(NUM_VERTICES - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_RELAX  = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [3:0]    root_reg;
    logic [VB-1:0] u_reg, u_next;        // vertex whose row is being relaxed
    logic [VB-1:0] cnt_reg, cnt_next;    // vertices added besides the root
    logic [CB-1:0] rcnt_reg, rcnt_next;  // row read pointer
    logic          rd_vld_reg;
    logic [VB-1:0] rd_col_reg;
    logic          go_reg, go_next;      // inject a search token at cell 0
    logic [VB-1:0] emit_reg, emit_next;

    logic          out_vld_reg, out_vld_next;
    logic [3:0]    out_vertex_reg, out_parent_reg;
    logic [15:0]   out_weight_reg;
    logic          out_root_reg, out_reached_reg, out_last_reg;

    logic          req_fire, start, row_ok, col_ok, ram_we, issue;
    logic          relax_done, tok_done, emit_load;
    logic [VB-1:0] root_sel;
    logic [AW-1:0] waddr, raddr;
    logic [WEIGHT_BITS-1:0] ram_rdata;
    prim_mst_ctl_t ctl;
    logic [VB-1:0] mark_idx;

    logic [NUM_VERTICES:0]  tok_vld, tok_found;
    logic [VB-1:0]          tok_idx [NUM_VERTICES+1];
    logic [WEIGHT_BITS-1:0] tok_key [NUM_VERTICES+1];
    logic [WEIGHT_BITS-1:0] cell_key [NUM_VERTICES];
    logic [VB-1:0]          cell_parent [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] cell_tree;

    logic          e_root, e_linked;

    // Root register; writes must arrive only while idle, which the block itself does not enforce
    assign setup.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= 4'd15;
        end
        else if (setup.valid && setup.ready)
        begin
            root_reg <= setup.data;
        end
    end

    // Saturate an out-of-range root to the last vertex
    assign root_sel = (int'(root_reg) < NUM_VERTICES) ? VB'(root_reg) : LAST_V;

    // Request decode
    assign request.ready = (state_reg == S_IDLE);
    assign req_fire      = request.valid && request.ready;
    assign start         = req_fire && (request.command == CMD_RUN);
    assign row_ok        = int'(request.row) < NUM_VERTICES;
    assign col_ok        = int'(request.col) < NUM_VERTICES;
    assign ram_we        = req_fire && (request.command == CMD_LOAD) && row_ok && col_ok;
    assign waddr         = AW'(request.row) * AW'(NUM_VERTICES) + AW'(request.col);

    // Row streaming: one entry per cycle, read data returns in the next cycle
    assign issue      = (state_reg == S_RELAX) && (int'(rcnt_reg) < NUM_VERTICES);
    assign raddr      = AW'(u_reg) * AW'(NUM_VERTICES) + AW'(rcnt_reg[VB-1:0]);
    assign relax_done = rd_vld_reg && (rd_col_reg == LAST_V);

    prim_mst_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (NUM_VERTICES * NUM_VERTICES)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (WEIGHT_BITS'(request.weight)),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // Search token leaves the last cell with the winner
    assign tok_done = tok_vld[NUM_VERTICES];

    // Broadcast control to the cells
    always_comb
    begin
        ctl.clear = start;
        ctl.mark  = start || ((state_reg == S_SEARCH) && tok_done && tok_found[NUM_VERTICES]);
        ctl.relax = rd_vld_reg;
        mark_idx  = start ? root_sel : tok_idx[NUM_VERTICES];
    end

    assign tok_vld[0]   = go_reg;
    assign tok_found[0] = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_key[0]   = '0;

    for (genvar gi = 0; gi < NUM_VERTICES; gi++)
    begin : g_cell
        prim_mst_cell #(
            .WEIGHT_BITS (WEIGHT_BITS),
            .VERTEX_BITS (VB),
            .CELL_INDEX  (gi)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctl           (ctl),
            .mark_idx      (mark_idx),
            .rel_src       (u_reg),
            .rel_col       (rd_col_reg),
            .rel_weight    (ram_rdata),
            .tok_vld_in    (tok_vld[gi]),
            .tok_found_in  (tok_found[gi]),
            .tok_idx_in    (tok_idx[gi]),
            .tok_key_in    (tok_key[gi]),
            .tok_vld_out   (tok_vld[gi+1]),
            .tok_found_out (tok_found[gi+1]),
            .tok_idx_out   (tok_idx[gi+1]),
            .tok_key_out   (tok_key[gi+1]),
            .key           (cell_key[gi]),
            .in_tree       (cell_tree[gi]),
            .parent        (cell_parent[gi])
        );
    end

    // Result register: load the next vertex when the slot is free or draining
    assign emit_load = (state_reg == S_EMIT) && (!out_vld_reg || result.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        u_next     = u_reg;
        cnt_next   = cnt_reg;
        rcnt_next  = rcnt_reg;
        go_next    = 1'b0;
        emit_next  = emit_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    u_next     = root_sel;
                    cnt_next   = '0;
                    rcnt_next  = '0;
                    state_next = S_RELAX;
                end
            end
            S_RELAX:
            begin
                if (issue)
                begin
                    rcnt_next = rcnt_reg + CB'(1);
                end
                if (relax_done)
                begin
                    if (cnt_reg == LAST_V)
                    begin
                        emit_next  = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        go_next    = 1'b1;
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                if (tok_done)
                begin
                    if (tok_found[NUM_VERTICES])
                    begin
                        u_next     = tok_idx[NUM_VERTICES];
                        cnt_next   = cnt_reg + VB'(1);
                        rcnt_next  = '0;
                        state_next = S_RELAX;
                    end
                    else
                    begin
                        // disconnected: stop and report what was reached
                        emit_next  = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    emit_next = emit_reg + VB'(1);
                    if (emit_reg == LAST_V)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        e_root   = (emit_reg == root_sel);
        e_linked = cell_tree[emit_reg] && !e_root;
        if (emit_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rd_vld_reg  <= 1'b0;
            go_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
            cnt_reg     <= '0;
            rcnt_reg    <= '0;
            emit_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue;
            go_reg      <= go_next;
            out_vld_reg <= out_vld_next;
            cnt_reg     <= cnt_next;
            rcnt_reg    <= rcnt_next;
            emit_reg    <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        rd_col_reg <= rcnt_reg[VB-1:0];
        if (emit_load)
        begin
            out_vertex_reg  <= 4'(emit_reg);
            out_parent_reg  <= e_linked ? 4'(cell_parent[emit_reg]) : 4'd0;
            out_weight_reg  <= e_linked ? 16'(cell_key[emit_reg]) : 16'd0;
            out_root_reg    <= e_root;
            out_reached_reg <= cell_tree[emit_reg];
            out_last_reg    <= (emit_reg == LAST_V);
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.vertex      = out_vertex_reg;
    assign result.parent      = out_parent_reg;
    assign result.edge_weight = out_weight_reg;
    assign result.is_root     = out_root_reg;
    assign result.reached     = out_reached_reg;
    assign result.last        = out_last_reg;
endmodule

/* rtl/prim_mst_checker.sv */
// Port-level checks for the Prim spanning tree engine, bound to its top level.
// Depends on prim_minimum_spanning_tree and its channel interfaces.
module prim_mst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [3:0]  res_vertex,
    input logic [3:0]  res_parent,
    input logic [15:0] res_weight,
    input logic        res_root,
    input logic        res_reached,
    input logic        res_last
);
    // a pending result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_root: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_root |-> res_reached && res_parent == 4'd0 && res_weight == 16'd0)
        else $error("root result malformed");

    a_unreached: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_reached |-> res_parent == 4'd0 && res_weight == 16'd0 && !res_root)
        else $error("unreached vertex carries an edge");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last ##1 res_valid
        |-> res_vertex == 4'($past(res_vertex) + 4'd1))
        else $error("results out of vertex order");
endmodule

bind prim_minimum_spanning_tree prim_mst_checker u_prim_mst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_vertex  (result.vertex),
    .res_parent  (result.parent),
    .res_weight  (result.edge_weight),
    .res_root    (result.is_root),
    .res_reached (result.reached),
    .res_last    (result.last)
);
